// ===== rtl/core/msp_pkg.sv =====
package msp_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = RING_AW + 1;
  localparam int MAX_BURST  = 20;
  localparam int CNT_W      = 5;
  localparam int NUM_AXES   = 6;
  localparam int SCALE_W    = 10;

  localparam logic [1:0] KIND_PUSH    = 2'd0;
  localparam logic [1:0] KIND_EMIT    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic REC_HEADER = 1'b0;
  localparam logic REC_SAMPLE = 1'b1;

  localparam logic [SCALE_W-1:0] ACC_SCALE = 10'd1000;
  localparam logic [SCALE_W-1:0] ROT_SCALE = 10'd100;

  localparam logic [CNT_W-1:0] MAX_PER_PACKET_RST = 5'd20;
  localparam logic [31:0]      OFFSET_SAT         = 32'd65535;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        time_ms;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [7:0]  link_rssi;
  } item_t;

  typedef struct packed {
    logic               record_kind;
    logic               last;
    logic [31:0]        seq_number;
    logic [31:0]        time_value;
    logic signed [7:0]  rssi_dbm;
    logic [CNT_W-1:0]   sample_count;
    logic signed [15:0] q_acc_x;
    logic signed [15:0] q_acc_y;
    logic signed [15:0] q_acc_z;
    logic signed [15:0] q_rot_x;
    logic signed [15:0] q_rot_y;
    logic signed [15:0] q_rot_z;
  } record_t;

  typedef struct packed {
    logic [31:0]                 time_ms;
    logic [NUM_AXES-1:0][15:0]   q;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/msp_if.sv =====
interface msp_in_if;
  logic            valid;
  logic            ready;
  msp_pkg::item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface msp_out_if;
  logic              valid;
  logic              ready;
  msp_pkg::record_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/motion_sample_packetizer.sv =====
// push: accepted and captured, then scale multiply and ring write before the next request
// emit: read at accept, header load; per sample a ring read and output load; loads wait on ready
// release: applied at accept; sample pace is set by the ring read and the one output register
// reset: synchronous, clears ring head pointer, fill, sequence, emitted count; max_per_packet to 20
// ring contents are not cleared; only written entries are ever read
module motion_sample_packetizer (
  input  logic                        clk,
  input  logic                        rst,
  msp_in_if.sink                      item,
  msp_out_if.source                   record,
  input  logic                        cfg_wr_en,
  input  logic [msp_pkg::CNT_W-1:0]   cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WR,
    ST_HDR,
    ST_RD,
    ST_OUT
  } state_t;

  localparam int AW = msp_pkg::RING_AW;
  localparam int FW = msp_pkg::FILL_W;
  localparam int CW = msp_pkg::CNT_W;

  state_t                  state;
  logic [AW-1:0]           head_ptr;
  logic [FW-1:0]           fill_count;
  logic [31:0]             seq_counter;
  logic [CW-1:0]           emitted_count;
  logic [CW-1:0]           max_per_packet;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           idx;
  logic [31:0]             base;
  logic signed [7:0]       rssi;
  logic [AW-1:0]           wr_pos;
  msp_pkg::item_t          item_r;
  logic                    rec_valid;
  msp_pkg::record_t        rec;

  logic                    item_fire;
  logic                    out_free;
  logic [CW-1:0]           cnt_c;
  logic                    emit_go;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  msp_pkg::entry_t         ram_rdata;
  msp_pkg::entry_t         ram_wdata;
  logic [31:0]             dt;
  logic signed [31:0]      raw [msp_pkg::NUM_AXES];
  logic [15:0]             qv  [msp_pkg::NUM_AXES];
  logic                    rec_load;
  msp_pkg::record_t        rec_next;

  assign item.ready   = (state == ST_IDLE);
  assign item_fire    = item.valid && item.ready;
  assign record.valid = rec_valid;
  assign record.payload = rec;
  assign out_free     = !rec_valid || record.ready;

  always_comb begin
    cnt_c = (fill_count < FW'(max_per_packet)) ? fill_count[CW-1:0] : max_per_packet;
    emit_go = item_fire && (item.payload.kind == msp_pkg::KIND_EMIT) &&
              (fill_count != '0) && (cnt_c <= CW'(msp_pkg::MAX_BURST));
    ram_re    = emit_go || (state == ST_RD);
    ram_raddr = head_ptr + ((state == ST_RD) ? AW'(idx) : '0);
    dt        = ram_rdata.time_ms - base;
  end

  always_comb begin
    rec_load = ((state == ST_HDR) || (state == ST_OUT)) && out_free;
    rec_next = '0;
    if (state == ST_HDR) begin
      rec_next.record_kind  = msp_pkg::REC_HEADER;
      rec_next.last         = (cnt == '0);
      rec_next.seq_number   = seq_counter;
      rec_next.time_value   = ram_rdata.time_ms;
      rec_next.rssi_dbm     = rssi;
      rec_next.sample_count = cnt;
    end else begin
      rec_next.record_kind = msp_pkg::REC_SAMPLE;
      rec_next.last        = (idx + CW'(1) == cnt);
      rec_next.time_value  = (dt > msp_pkg::OFFSET_SAT) ? msp_pkg::OFFSET_SAT : dt;
      rec_next.q_acc_x     = ram_rdata.q[5];
      rec_next.q_acc_y     = ram_rdata.q[4];
      rec_next.q_acc_z     = ram_rdata.q[3];
      rec_next.q_rot_x     = ram_rdata.q[2];
      rec_next.q_rot_y     = ram_rdata.q[1];
      rec_next.q_rot_z     = ram_rdata.q[0];
    end
  end

  assign raw[0] = item_r.acc_x;
  assign raw[1] = item_r.acc_y;
  assign raw[2] = item_r.acc_z;
  assign raw[3] = item_r.rot_x;
  assign raw[4] = item_r.rot_y;
  assign raw[5] = item_r.rot_z;

  for (genvar a = 0; a < msp_pkg::NUM_AXES; a++) begin : g_quant
    msp_quant u_quant (
      .clk   (clk),
      .en    (state == ST_MUL),
      .raw   (raw[a]),
      .scale ((a < 3) ? msp_pkg::ACC_SCALE : msp_pkg::ROT_SCALE),
      .q     (qv[a])
    );
  end

  always_comb begin
    ram_wdata.time_ms = item_r.time_ms;
    for (int a = 0; a < msp_pkg::NUM_AXES; a++) begin
      ram_wdata.q[msp_pkg::NUM_AXES-1-a] = qv[a];
    end
  end

  msp_ram u_ram (
    .clk   (clk),
    .we    (state == ST_WR),
    .waddr (wr_pos),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head_ptr       <= '0;
      fill_count     <= '0;
      seq_counter    <= '0;
      emitted_count  <= '0;
      max_per_packet <= msp_pkg::MAX_PER_PACKET_RST;
      rec_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_per_packet <= cfg_wr_data;
      end
      if (rec_load) begin
        rec_valid <= 1'b1;
        rec       <= rec_next;
      end else if (record.ready) begin
        rec_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            item_r <= item.payload;
            case (item.payload.kind)
              msp_pkg::KIND_PUSH: begin
                if (fill_count < FW'(msp_pkg::RING_DEPTH)) begin
                  wr_pos     <= head_ptr + fill_count[AW-1:0];
                  fill_count <= fill_count + FW'(1);
                end else begin
                  wr_pos   <= head_ptr;
                  head_ptr <= head_ptr + AW'(1);
                end
                state <= ST_MUL;
              end
              msp_pkg::KIND_EMIT: begin
                emitted_count <= emit_go ? cnt_c : '0;
                if (emit_go) begin
                  cnt           <= cnt_c;
                  rssi          <= item.payload.link_rssi;
                  idx           <= '0;
                  state         <= ST_HDR;
                end
              end
              msp_pkg::KIND_RELEASE: begin
                if (FW'(emitted_count) >= fill_count) begin
                  head_ptr   <= '0;
                  fill_count <= '0;
                end else begin
                  head_ptr   <= head_ptr + AW'(emitted_count);
                  fill_count <= fill_count - FW'(emitted_count);
                end
                seq_counter   <= seq_counter + 32'd1;
                emitted_count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_WR;
        end
        ST_WR: begin
          state <= ST_IDLE;
        end
        ST_HDR: begin
          if (out_free) begin
            base  <= ram_rdata.time_ms;
            state <= (cnt == '0) ? ST_IDLE : ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            idx   <= idx + CW'(1);
            state <= (idx + CW'(1) == cnt) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(msp_pkg::RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_emitted_bound: assert property (@(posedge clk) disable iff (rst)
    emitted_count <= CW'(msp_pkg::MAX_BURST))
    else $error("emitted count beyond burst limit");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    item_fire && (item.payload.kind == msp_pkg::KIND_RELEASE) |=> emitted_count == '0)
    else $error("release left emitted count set");

  a_sample_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD || state == ST_OUT) |-> idx < cnt)
    else $error("sample index past packet count");

endmodule

// ===== rtl/core/msp_quant.sv =====
module msp_quant (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [31:0]           raw,
  input  logic [msp_pkg::SCALE_W-1:0]  scale,
  output logic [15:0]                  q
);

  localparam int PROD_W = 32 + msp_pkg::SCALE_W;
  localparam int QM_W   = PROD_W - 16;

  logic              neg;
  logic [PROD_W-1:0] prod;
  logic [31:0]       mag;
  logic [PROD_W-1:0] rnd;
  logic [QM_W-1:0]   qm;

  assign mag = raw[31] ? (32'd0 - raw) : raw;

  // magnitude times scale, registered
  always_ff @(posedge clk) begin
    if (en) begin
      neg  <= raw[31];
      prod <= PROD_W'(mag) * PROD_W'(scale);
    end
  end

  // round half away from zero, saturate to int16
  always_comb begin
    rnd = prod + PROD_W'(32768);
    qm  = rnd[PROD_W-1:16];
    if (!neg) begin
      q = (qm > QM_W'(32767)) ? 16'h7FFF : qm[15:0];
    end else begin
      q = (qm > QM_W'(32768)) ? 16'h8000 : (16'd0 - qm[15:0]);
    end
  end

endmodule

// ===== rtl/core/msp_ram.sv =====
module msp_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [msp_pkg::RING_AW-1:0]  waddr,
  input  msp_pkg::entry_t              wdata,
  input  logic                         re,
  input  logic [msp_pkg::RING_AW-1:0]  raddr,
  output msp_pkg::entry_t              rdata
);

  msp_pkg::entry_t mem [msp_pkg::RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
